[hw/rtl/twtlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twtlc_pkg
// Types and constants shared by the two-way traffic light controller.
// ----------------------------------------------------------------------------
package twtlc_pkg;

  // Lamp bit positions within the six-bit lamp pattern
  localparam int unsigned LampR1 = 0;
  localparam int unsigned LampY1 = 1;
  localparam int unsigned LampG1 = 2;
  localparam int unsigned LampR2 = 3;
  localparam int unsigned LampY2 = 4;
  localparam int unsigned LampG2 = 5;

  // Phase codes
  localparam logic [2:0] PH_ONE_GREEN   = 3'd0;
  localparam logic [2:0] PH_ONE_YELLOW  = 3'd1;
  localparam logic [2:0] PH_TWO_GREEN   = 3'd2;
  localparam logic [2:0] PH_TWO_YELLOW  = 3'd3;
  localparam logic [2:0] PH_HANDOVER    = 3'd4;

  // Command codes
  localparam logic [1:0] CMD_NONE       = 2'd0;
  localparam logic [1:0] CMD_HEAD_ONE   = 2'd1;
  localparam logic [1:0] CMD_HEAD_TWO   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DARK_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_GREEN_TICKS    = 3'd1;
  localparam logic [2:0] REG_YELLOW_TICKS   = 3'd2;
  localparam logic [2:0] REG_HANDOVER_TICKS = 3'd3;
  localparam logic [2:0] REG_FLASH_TICKS    = 3'd4;

  // Register reset values
  localparam logic [11:0] DARK_THRESHOLD_RST = 12'd300;
  localparam logic [7:0]  GREEN_TICKS_RST    = 8'd3;
  localparam logic [7:0]  YELLOW_TICKS_RST   = 8'd1;
  localparam logic [7:0]  HANDOVER_TICKS_RST = 8'd1;
  localparam logic [7:0]  FLASH_TICKS_RST    = 8'd1;

  // Result of applying a phase
  typedef struct packed {
    logic [5:0] lamps;
    logic [2:0] next_phase;
    logic [7:0] countdown;
  } phase_apply_t;

endpackage
`default_nettype wire

[hw/rtl/two_way_traffic_light_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input yields a result registered onto m_tdata. Throughput:
// one item per cycle while s_tready is high; the whole phase/flash update is
// a single pass of logic from the state registers into the result register,
// and a skid register keeps the input side open while a result waits downstream.
// Reset (synchronous, active high): registers to defaults, phase zero applied
// (head one green, head two red, phase one pending), day mode, buffers empty.
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller_core
// Five-phase two-head traffic light sequencer with night flashing mode,
// stream in/out and an APB register port.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // light_level[11:0], command[13:12], time_tick[14]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata    // red_one, yellow_one, green_one, red_two,
                                      // yellow_two, green_two, night_active [6]
);
  import twtlc_pkg::*;

  // configuration registers
  logic [11:0] dark_threshold;
  logic [7:0]  green_ticks;
  logic [7:0]  yellow_ticks;
  logic [7:0]  handover_ticks;
  logic [7:0]  flash_ticks;

  // controller state
  logic [2:0]  next_phase, next_phase_next;
  logic [7:0]  phase_countdown, phase_countdown_next;
  logic [5:0]  lamp_pattern, lamp_pattern_next;
  logic        night_mode, night_mode_next;
  logic [7:0]  flash_countdown, flash_countdown_next;
  logic        flash_level, flash_level_next;

  // output register and skid stage
  logic        out_valid;
  logic [6:0]  out_data;
  logic        skid_valid;
  logic [6:0]  skid_data;
  logic [6:0]  result;

  logic        in_acc;
  logic        out_acc;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic [11:0] light_level;
  logic [1:0]  command;
  logic        time_tick;

  assign light_level = s_tdata[11:0];
  assign command     = s_tdata[13:12];
  assign time_tick   = s_tdata[14];

  function automatic phase_apply_t apply_phase(
    input logic [2:0] phase,
    input logic [5:0] lamps,
    input logic [7:0] g_ticks,
    input logic [7:0] y_ticks,
    input logic [7:0] h_ticks
  );
    phase_apply_t r;
    r.lamps = lamps;
    case (phase)
      PH_ONE_YELLOW: begin
        r.lamps[2:0]  = 3'b000;
        r.lamps[LampY1] = 1'b1;
        r.next_phase  = PH_TWO_GREEN;
        r.countdown   = y_ticks;
      end
      PH_TWO_GREEN: begin
        r.lamps       = 6'b000000;
        r.lamps[LampR1] = 1'b1;
        r.lamps[LampG2] = 1'b1;
        r.next_phase  = PH_TWO_YELLOW;
        r.countdown   = g_ticks;
      end
      PH_TWO_YELLOW: begin
        r.lamps[5:3]  = 3'b000;
        r.lamps[LampY2] = 1'b1;
        r.next_phase  = PH_HANDOVER;
        r.countdown   = y_ticks;
      end
      PH_HANDOVER: begin
        r.lamps       = 6'b000000;
        r.lamps[LampR2] = 1'b1;
        r.lamps[LampG1] = 1'b1;
        r.next_phase  = PH_ONE_GREEN;
        r.countdown   = h_ticks;
      end
      default: begin
        r.lamps       = 6'b000000;
        r.lamps[LampG1] = 1'b1;
        r.lamps[LampR2] = 1'b1;
        r.next_phase  = PH_ONE_YELLOW;
        r.countdown   = g_ticks;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- handshakes
  assign s_tready = !skid_valid;
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= DARK_THRESHOLD_RST;
      green_ticks    <= GREEN_TICKS_RST;
      yellow_ticks   <= YELLOW_TICKS_RST;
      handover_ticks <= HANDOVER_TICKS_RST;
      flash_ticks    <= FLASH_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DARK_THRESHOLD: dark_threshold <= pwdata[11:0];
        REG_GREEN_TICKS:    green_ticks    <= pwdata[7:0];
        REG_YELLOW_TICKS:   yellow_ticks   <= pwdata[7:0];
        REG_HANDOVER_TICKS: handover_ticks <= pwdata[7:0];
        REG_FLASH_TICKS:    flash_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DARK_THRESHOLD: prdata = {20'd0, dark_threshold};
      REG_GREEN_TICKS:    prdata = {24'd0, green_ticks};
      REG_YELLOW_TICKS:   prdata = {24'd0, yellow_ticks};
      REG_HANDOVER_TICKS: prdata = {24'd0, handover_ticks};
      REG_FLASH_TICKS:    prdata = {24'd0, flash_ticks};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    phase_apply_t ap;
    ap                   = '0;
    next_phase_next      = next_phase;
    phase_countdown_next = phase_countdown;
    lamp_pattern_next    = lamp_pattern;
    night_mode_next      = night_mode;
    flash_countdown_next = flash_countdown;
    flash_level_next     = flash_level;

    // tick acts first on the prior state
    if (time_tick) begin
      if (night_mode) begin
        if (flash_countdown <= 8'd1) begin
          flash_level_next     = !flash_level;
          flash_countdown_next = flash_ticks;
        end else begin
          flash_countdown_next = flash_countdown - 8'd1;
        end
      end else if (phase_countdown <= 8'd1) begin
        ap = apply_phase(next_phase, lamp_pattern, green_ticks, yellow_ticks,
                         handover_ticks);
        lamp_pattern_next    = ap.lamps;
        next_phase_next      = ap.next_phase;
        phase_countdown_next = ap.countdown;
      end else begin
        phase_countdown_next = phase_countdown - 8'd1;
      end
    end

    // command darkens the heads and picks the pending phase
    if (command == CMD_HEAD_ONE || command == CMD_HEAD_TWO) begin
      lamp_pattern_next = 6'b000000;
      flash_level_next  = 1'b0;
      next_phase_next   = (command == CMD_HEAD_ONE) ? PH_ONE_GREEN : PH_TWO_GREEN;
    end

    // light comparison last
    if (light_level <= dark_threshold) begin
      if (!night_mode) begin
        night_mode_next      = 1'b1;
        lamp_pattern_next    = 6'b000000;
        flash_level_next     = 1'b0;
        flash_countdown_next = flash_ticks;
      end
    end else if (night_mode) begin
      night_mode_next      = 1'b0;
      ap = apply_phase(next_phase_next, 6'b000000, green_ticks, yellow_ticks,
                       handover_ticks);
      lamp_pattern_next    = ap.lamps;
      next_phase_next      = ap.next_phase;
      phase_countdown_next = ap.countdown;
    end

    if (night_mode_next) begin
      result = {1'b1, 1'b0, flash_level_next, 2'b00, flash_level_next, 1'b0};
    end else begin
      result = {1'b0, lamp_pattern_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_phase      <= PH_ONE_YELLOW;
      phase_countdown <= GREEN_TICKS_RST;
      lamp_pattern    <= 6'b001100;  // head one green, head two red
      night_mode      <= 1'b0;
      flash_countdown <= 8'd0;
      flash_level     <= 1'b0;
    end else if (in_acc) begin
      next_phase      <= next_phase_next;
      phase_countdown <= phase_countdown_next;
      lamp_pattern    <= lamp_pattern_next;
      night_mode      <= night_mode_next;
      flash_countdown <= flash_countdown_next;
      flash_level     <= flash_level_next;
    end
  end

  // ---------------------------------------------------------------- output side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_acc) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      // advance the skid entry, or take the fresh result straight through
      out_data <= skid_valid ? skid_data : result;
    end else if (in_acc && !out_valid) begin
      out_data <= result;
    end
    if (in_acc && out_valid && !out_acc) begin
      skid_data <= result;  // hold the new result while the old one waits
    end
  end

  // ---------------------------------------------------------------- assertions
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry present with empty output register");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[6]) |->
      (!out_data[LampR1] && !out_data[LampG1] && !out_data[LampR2] && !out_data[LampG2]))
    else $error("red or green lamp on in night mode");

  assert property (@(posedge clk) disable iff (rst)
    !(lamp_pattern[LampG1] && lamp_pattern[LampG2]))
    else $error("both heads green");

  assert property (@(posedge clk) disable iff (rst) next_phase <= PH_HANDOVER)
    else $error("pending phase out of range");

endmodule
`default_nettype wire
